[hdl/pgm_pkg.sv]
`default_nettype none
package pgm_pkg;

  // window geometry
  localparam int WINDOW     = 17;
  localparam int HALF       = WINDOW / 2;
  localparam int VROWS      = WINDOW + 1;
  localparam int SROWS      = HALF + 2;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROWW       = 10;
  localparam int HW         = 11;
  localparam int VRW        = $clog2(VROWS);
  localparam int SRW        = $clog2(SROWS);
  localparam int GW         = $clog2(WINDOW);

  // window statistics
  localparam int AREA       = WINDOW * WINDOW;
  localparam int FLOOR_TERM = 10 * 255 * AREA;
  localparam int SUMW       = 17;
  localparam int SQW        = 25;
  localparam int PRODW      = 34;
  localparam int DENW       = 20;

  // root chain: 68-bit radicand, top half carried, low half zero
  localparam int SQ_XW    = 34;
  localparam int SQ_RW    = 38;
  localparam int SQ_ROOTW = 34;
  localparam int SQ_CELLS = SQ_ROOTW;

  // divider chain: saturating 16-bit quotient
  localparam int DV_NW    = 35;
  localparam int DV_DW    = 21;
  localparam int DV_QW    = 16;

  // photometric rounding: (2*num + 65025) / 130050
  localparam int P_ROUND   = 65025;
  localparam int P_DIVISOR = 130050;

  typedef struct packed {
    logic                vld;
    logic [SQ_XW-1:0]    x;
    logic [SQ_RW-1:0]    rem;
    logic [SQ_ROOTW-1:0] root;
  } sqrt_stage_t;

  typedef struct packed {
    logic             vld;
    logic [DV_QW-1:0] num;
    logic [DV_DW-1:0] rem;
    logic [DV_QW-1:0] quo;
    logic [DV_DW-1:0] dvs;
  } div_stage_t;

endpackage
`default_nettype wire

[hdl/pgm_sqrt_cell.sv]
`default_nettype none
// one radix-4 digit of a restoring square root
module pgm_sqrt_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pgm_pkg::sqrt_stage_t stage_i,
  output pgm_pkg::sqrt_stage_t      stage_o
);

  logic [pgm_pkg::SQ_RW-1:0] trial;
  logic [pgm_pkg::SQ_RW-1:0] part;
  logic                      fits;
  pgm_pkg::sqrt_stage_t      nxt;
  logic                      vld_q;
  pgm_pkg::sqrt_stage_t      data_q;

  always_comb begin
    part  = {stage_i.rem[pgm_pkg::SQ_RW-3:0], stage_i.x[pgm_pkg::SQ_XW-1 -: 2]};
    trial = pgm_pkg::SQ_RW'({stage_i.root, 2'b01});
    fits  = part >= trial;
    nxt.vld  = stage_i.vld;
    nxt.x    = {stage_i.x[pgm_pkg::SQ_XW-3:0], 2'b00};
    nxt.rem  = fits ? part - trial : part;
    nxt.root = {stage_i.root[pgm_pkg::SQ_ROOTW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= nxt.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    stage_o     = data_q;
    stage_o.vld = vld_q;
  end

endmodule
`default_nettype wire

[hdl/pgm_div_cell.sv]
`default_nettype none
// one bit of a restoring divide
module pgm_div_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pgm_pkg::div_stage_t stage_i,
  output pgm_pkg::div_stage_t      stage_o
);

  logic [pgm_pkg::DV_DW:0]   part;
  logic                      fits;
  pgm_pkg::div_stage_t       nxt;
  logic                      vld_q;
  pgm_pkg::div_stage_t       data_q;

  always_comb begin
    part = {stage_i.rem, stage_i.num[pgm_pkg::DV_QW-1]};
    fits = part >= {1'b0, stage_i.dvs};
    nxt.vld = stage_i.vld;
    nxt.num = {stage_i.num[pgm_pkg::DV_QW-2:0], 1'b0};
    nxt.rem = fits ? pgm_pkg::DV_DW'(part - {1'b0, stage_i.dvs})
                   : pgm_pkg::DV_DW'(part);
    nxt.quo = {stage_i.quo[pgm_pkg::DV_QW-2:0], fits};
    nxt.dvs = stage_i.dvs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= nxt.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt;
  end

  always_comb begin
    stage_o     = data_q;
    stage_o.vld = vld_q;
  end

endmodule
`default_nettype wire

[hdl/photometric_glare_map.sv]
`default_nettype none
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   opcode, blue, green, red
// out       source     out_valid/out_stall photometric .. frame_max
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data (11 bits)
//
// A pixel that yields no result runs its saturation quotient through the 16-cell
// divider. A request that yields a result also makes the 289 serial reads of the
// value store (one read port), passes the 34-cell root chain and makes two more
// divider passes. A flush that drains does that work without the saturation divide.
// Reset clears the control state only; the line stores are never cleared.
// A finished result waits in the output register while the next request is taken.
module photometric_glare_map #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  red_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      photometric_o,
  output logic [7:0]       intensity_o,
  output logic [7:0]       saturation_o,
  output logic [15:0]      local_contrast_o,
  output logic             last_of_frame_o,
  output logic [15:0]      frame_min_o,
  output logic [15:0]      frame_max_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int PW  = $clog2(pgm_pkg::HALF * MAX_WIDTH + pgm_pkg::HALF + 2);
  localparam int XIW = WW + 2;
  localparam int YIW = pgm_pkg::HW + 2;
  localparam int TRW = pgm_pkg::VRW + 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_SDIV    = 14'b00000000000010,
    ST_READS   = 14'b00000000000100,
    ST_GATHER  = 14'b00000000001000,
    ST_DRAIN   = 14'b00000000010000,
    ST_PREP1   = 14'b00000000100000,
    ST_PREP2   = 14'b00000001000000,
    ST_SQRT    = 14'b00000010000000,
    ST_CDIV    = 14'b00000100000000,
    ST_MUL1    = 14'b00001000000000,
    ST_MUL2    = 14'b00010000000000,
    ST_PLAUNCH = 14'b00100000000000,
    ST_PDIV    = 14'b01000000000000,
    ST_EMIT    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration and stream position
  logic [10:0]                  frame_width_q, frame_width_d;
  logic [10:0]                  frame_height_q, frame_height_d;
  logic [pgm_pkg::ROWW-1:0]     in_row_q, in_row_d, out_row_q, out_row_d;
  logic [CW-1:0]                in_col_q, in_col_d, out_col_q, out_col_d;
  logic [pgm_pkg::VRW-1:0]      in_rm18_q, in_rm18_d, out_rm18_q, out_rm18_d;
  logic [pgm_pkg::SRW-1:0]      in_rm10_q, in_rm10_d, out_rm10_q, out_rm10_d;
  logic [PW-1:0]                pend_q, pend_d, pend_new, delay;
  logic [15:0]                  min_q, min_d, max_q, max_d;
  logic                         out_vld_q, out_vld_d;
  logic                         emit_q, emit_d;
  logic [pgm_pkg::GW-1:0]       gx_q, gx_d, gy_q, gy_d;
  logic                         rd_vld_q, rd_vld_d, rd_ctr_q, rd_ctr_d;
  logic                         div_go_q, div_go_d, sqrt_go_q, sqrt_go_d;

  logic [WW-1:0]                act_w;
  logic [pgm_pkg::HW-1:0]       act_h;
  logic                         at_start, can_load, vmem_we, smem_we;

  // pixel colour conversion
  logic [7:0]                   v_pix, mn_pix;
  logic [16:0]                  s_num;

  // line stores
  logic [7:0] vmem [pgm_pkg::VROWS][MAX_WIDTH];
  logic [7:0] smem [pgm_pkg::SROWS][MAX_WIDTH];
  logic [pgm_pkg::VRW-1:0]      rd_row;
  logic [CW-1:0]                rd_col;
  logic [pgm_pkg::SRW-1:0]      swr_row_q;
  logic [CW-1:0]                swr_col_q;
  logic                         vzero_q;
  logic [7:0]                   v_rd_q, s_rd_q, v_ctr_q;

  // window statistics and arithmetic
  logic [pgm_pkg::SUMW-1:0]     sum_q;
  logic [pgm_pkg::SQW-1:0]      sq_q;
  logic [pgm_pkg::PRODW-1:0]    a289_q, ss_q;
  logic [pgm_pkg::DENW-1:0]     den_q;
  logic [pgm_pkg::SQ_XW-1:0]    sqrt_x_q, sqrt_x_d;
  logic [pgm_pkg::DV_NW-1:0]    div_n_q, div_n_d;
  logic [pgm_pkg::DV_DW-1:0]    div_d_q, div_d_d;
  logic [15:0]                  c_q, p_q, div_res;
  logic [15:0]                  m1_q;
  logic [32:0]                  m2_q;
  logic                         div_sat;
  logic [15:0]                  min_nx, max_nx;
  logic                         last_nx;

  pgm_pkg::sqrt_stage_t sq_chain [pgm_pkg::SQ_CELLS+1];
  pgm_pkg::div_stage_t  dv_chain [pgm_pkg::DV_QW+1];

  // ---------------------------------------------------------------------------
  // Frame size after clamping, pipeline delay
  // ---------------------------------------------------------------------------
  always_comb begin
    act_w = WW'(32'(frame_width_q) < pgm_pkg::HALF + 1 ? pgm_pkg::HALF + 1 :
                (32'(frame_width_q) > MAX_WIDTH ? MAX_WIDTH : 32'(frame_width_q)));
    act_h = pgm_pkg::HW'(32'(frame_height_q) < pgm_pkg::HALF + 1 ? pgm_pkg::HALF + 1 :
                (32'(frame_height_q) > pgm_pkg::MAX_HEIGHT ? pgm_pkg::MAX_HEIGHT :
                 32'(frame_height_q)));
    delay = PW'(32'(act_w) * pgm_pkg::HALF + pgm_pkg::HALF);
  end

  assign at_start = (in_row_q == '0) && (in_col_q == '0);
  assign can_load = !out_vld_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // HSV value and saturation numerator
  // ---------------------------------------------------------------------------
  always_comb begin
    v_pix  = blue_i;
    mn_pix = blue_i;
    if (green_i > v_pix)  v_pix  = green_i;
    if (red_i > v_pix)    v_pix  = red_i;
    if (green_i < mn_pix) mn_pix = green_i;
    if (red_i < mn_pix)   mn_pix = red_i;
    s_num = 17'(510 * (32'(v_pix) - 32'(mn_pix)) + 32'(v_pix));
  end

  // ---------------------------------------------------------------------------
  // Window read address, reflect-101 at every border
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [XIW-1:0] xi, wi;
    logic signed [YIW-1:0] yi, hi, dy_off;
    logic signed [TRW-1:0] tr;
    xi = $signed(XIW'(out_col_q)) + $signed(XIW'(gx_q)) - $signed(XIW'(pgm_pkg::HALF));
    wi = $signed(XIW'(act_w));
    if (xi < 0) xi = -xi;
    if (xi >= wi) xi = wi + wi - $signed(XIW'(2)) - xi;
    if (xi < 0) xi = '0;
    rd_col = xi[CW-1:0];

    yi = $signed(YIW'(out_row_q)) + $signed(YIW'(gy_q)) - $signed(YIW'(pgm_pkg::HALF));
    hi = $signed(YIW'(act_h));
    if (yi < 0) yi = -yi;
    if (yi >= hi) yi = hi + hi - $signed(YIW'(2)) - yi;
    if (yi < 0) yi = '0;
    // row slot relative to the centre row's slot, one wrap either way
    dy_off = yi - $signed(YIW'(out_row_q));
    tr = $signed(TRW'(out_rm18_q)) + $signed(dy_off[TRW-1:0]);
    if (tr < 0) tr = tr + $signed(TRW'(pgm_pkg::VROWS));
    else if (tr >= $signed(TRW'(pgm_pkg::VROWS))) tr = tr - $signed(TRW'(pgm_pkg::VROWS));
    rd_row = tr[pgm_pkg::VRW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Root chain: 34 cells, one digit each, handed on every cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    sq_chain[0].vld  = sqrt_go_q;
    sq_chain[0].x    = sqrt_x_q;
    sq_chain[0].rem  = '0;
    sq_chain[0].root = '0;
  end

  for (genvar k = 0; k < pgm_pkg::SQ_CELLS; k++) begin : g_sqrt
    pgm_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (sq_chain[k]),
      .stage_o (sq_chain[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Divider chain: 16 cells, shared by saturation, contrast and score
  // ---------------------------------------------------------------------------
  always_comb begin
    dv_chain[0].vld = div_go_q;
    dv_chain[0].num = div_n_q[pgm_pkg::DV_QW-1:0];
    dv_chain[0].rem = pgm_pkg::DV_DW'(div_n_q[pgm_pkg::DV_NW-1:pgm_pkg::DV_QW]);
    dv_chain[0].quo = '0;
    dv_chain[0].dvs = div_d_q;
  end

  for (genvar k = 0; k < pgm_pkg::DV_QW; k++) begin : g_div
    pgm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (dv_chain[k]),
      .stage_o (dv_chain[k+1])
    );
  end

  // quotient of 2^16 or more saturates
  assign div_sat = (pgm_pkg::DV_NW + 2)'(div_n_q) >= {div_d_q, 16'h0000};
  assign div_res = div_sat ? 16'hFFFF : dv_chain[pgm_pkg::DV_QW].quo;

  // ---------------------------------------------------------------------------
  // Frame extremes for the result being emitted
  // ---------------------------------------------------------------------------
  always_comb begin
    min_nx  = (p_q < min_q) ? p_q : min_q;
    max_nx  = (p_q > max_q) ? p_q : max_q;
    last_nx = ({1'b0, out_row_q} == act_h - pgm_pkg::HW'(1)) &&
              (WW'(out_col_q) == act_w - WW'(1));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    in_row_d       = in_row_q;
    in_col_d       = in_col_q;
    in_rm18_d      = in_rm18_q;
    in_rm10_d      = in_rm10_q;
    out_row_d      = out_row_q;
    out_col_d      = out_col_q;
    out_rm18_d     = out_rm18_q;
    out_rm10_d     = out_rm10_q;
    pend_d         = pend_q;
    pend_new       = pend_q;
    min_d          = min_q;
    max_d          = max_q;
    out_vld_d      = out_vld_q;
    emit_d         = emit_q;
    gx_d           = gx_q;
    gy_d           = gy_q;
    rd_vld_d       = 1'b0;
    rd_ctr_d       = 1'b0;
    div_go_d       = 1'b0;
    div_n_d        = '0;
    div_d_d        = '0;
    sqrt_go_d      = 1'b0;
    sqrt_x_d       = '0;
    vmem_we        = 1'b0;
    smem_we        = 1'b0;

    if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          // register write aborts the frame in progress
          if (cfg_index_i == REG_FRAME_WIDTH)  frame_width_d  = cfg_data_i;
          if (cfg_index_i == REG_FRAME_HEIGHT) frame_height_d = cfg_data_i;
          in_row_d = '0; in_col_d = '0; in_rm18_d = '0; in_rm10_d = '0;
          out_row_d = '0; out_col_d = '0; out_rm18_d = '0; out_rm10_d = '0;
          pend_d = '0;
          min_d  = 16'hFFFF;
          max_d  = '0;
        end else if (in_valid_i) begin
          if (opcode_i == OP_FLUSH) begin
            if (at_start && pend_q != '0) state_d = ST_READS;
          end else begin
            vmem_we  = 1'b1;
            div_go_d = 1'b1;
            div_n_d  = pgm_pkg::DV_NW'(s_num);
            div_d_d  = pgm_pkg::DV_DW'({v_pix, 1'b0});
            state_d  = ST_SDIV;
            if (at_start) begin
              // new frame drops anything left of the previous one
              out_row_d = '0; out_col_d = '0; out_rm18_d = '0; out_rm10_d = '0;
              min_d = 16'hFFFF;
              max_d = '0;
              pend_new = PW'(1);
            end else begin
              pend_new = pend_q + PW'(1);
            end
            pend_d = pend_new;
            emit_d = pend_new > delay;
            if (WW'(in_col_q) + WW'(1) >= act_w) begin
              in_col_d = '0;
              if (pgm_pkg::HW'(in_row_q) + pgm_pkg::HW'(1) >= act_h) begin
                in_row_d = '0; in_rm18_d = '0; in_rm10_d = '0;
              end else begin
                in_row_d  = in_row_q + pgm_pkg::ROWW'(1);
                in_rm18_d = (in_rm18_q == pgm_pkg::VRW'(pgm_pkg::VROWS - 1)) ? '0 :
                            in_rm18_q + pgm_pkg::VRW'(1);
                in_rm10_d = (in_rm10_q == pgm_pkg::SRW'(pgm_pkg::SROWS - 1)) ? '0 :
                            in_rm10_q + pgm_pkg::SRW'(1);
              end
            end else begin
              in_col_d = in_col_q + CW'(1);
            end
          end
        end
      end

      ST_SDIV: begin
        if (dv_chain[pgm_pkg::DV_QW].vld) begin
          smem_we = 1'b1;
          state_d = emit_q ? ST_READS : ST_IDLE;
        end
      end

      ST_READS: begin
        gx_d    = '0;
        gy_d    = '0;
        state_d = ST_GATHER;
      end

      ST_GATHER: begin
        rd_vld_d = 1'b1;
        rd_ctr_d = (gx_q == pgm_pkg::GW'(pgm_pkg::HALF)) && (gy_q == pgm_pkg::GW'(pgm_pkg::HALF));
        if (gy_q == pgm_pkg::GW'(pgm_pkg::WINDOW - 1)) begin
          gy_d = '0;
          if (gx_q == pgm_pkg::GW'(pgm_pkg::WINDOW - 1)) state_d = ST_DRAIN;
          else gx_d = gx_q + pgm_pkg::GW'(1);
        end else begin
          gy_d = gy_q + pgm_pkg::GW'(1);
        end
      end

      ST_DRAIN: state_d = ST_PREP1;
      ST_PREP1: state_d = ST_PREP2;

      ST_PREP2: begin
        sqrt_go_d = 1'b1;
        sqrt_x_d  = (a289_q >= ss_q) ? pgm_pkg::SQ_XW'(a289_q - ss_q) : '0;
        state_d   = ST_SQRT;
      end

      ST_SQRT: begin
        if (sq_chain[pgm_pkg::SQ_CELLS].vld) begin
          // contrast = floor((root + den) / (2 den))
          div_go_d = 1'b1;
          div_n_d  = pgm_pkg::DV_NW'(sq_chain[pgm_pkg::SQ_CELLS].root) +
                     pgm_pkg::DV_NW'(den_q);
          div_d_d  = pgm_pkg::DV_DW'({den_q, 1'b0});
          state_d  = ST_CDIV;
        end
      end

      ST_CDIV: if (dv_chain[pgm_pkg::DV_QW].vld) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_PLAUNCH;

      ST_PLAUNCH: begin
        div_go_d = 1'b1;
        div_n_d  = pgm_pkg::DV_NW'({m2_q, 1'b0}) + pgm_pkg::DV_NW'(pgm_pkg::P_ROUND);
        div_d_d  = pgm_pkg::DV_DW'(pgm_pkg::P_DIVISOR);
        state_d  = ST_PDIV;
      end

      ST_PDIV: if (dv_chain[pgm_pkg::DV_QW].vld) state_d = ST_EMIT;

      ST_EMIT: begin
        if (can_load) begin
          out_vld_d = 1'b1;
          min_d     = min_nx;
          max_d     = max_nx;
          pend_d    = pend_q - PW'(1);
          if (WW'(out_col_q) + WW'(1) >= act_w) begin
            out_col_d = '0;
            if (pgm_pkg::HW'(out_row_q) + pgm_pkg::HW'(1) >= act_h) begin
              out_row_d = '0; out_rm18_d = '0; out_rm10_d = '0;
            end else begin
              out_row_d  = out_row_q + pgm_pkg::ROWW'(1);
              out_rm18_d = (out_rm18_q == pgm_pkg::VRW'(pgm_pkg::VROWS - 1)) ? '0 :
                           out_rm18_q + pgm_pkg::VRW'(1);
              out_rm10_d = (out_rm10_q == pgm_pkg::SRW'(pgm_pkg::SROWS - 1)) ? '0 :
                           out_rm10_q + pgm_pkg::SRW'(1);
            end
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_width_q  <= 11'd640;
      frame_height_q <= 11'd480;
      in_row_q       <= '0;
      in_col_q       <= '0;
      in_rm18_q      <= '0;
      in_rm10_q      <= '0;
      out_row_q      <= '0;
      out_col_q      <= '0;
      out_rm18_q     <= '0;
      out_rm10_q     <= '0;
      pend_q         <= '0;
      min_q          <= 16'hFFFF;
      max_q          <= '0;
      out_vld_q      <= 1'b0;
      emit_q         <= 1'b0;
      gx_q           <= '0;
      gy_q           <= '0;
      rd_vld_q       <= 1'b0;
      rd_ctr_q       <= 1'b0;
      div_go_q       <= 1'b0;
      sqrt_go_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      in_row_q       <= in_row_d;
      in_col_q       <= in_col_d;
      in_rm18_q      <= in_rm18_d;
      in_rm10_q      <= in_rm10_d;
      out_row_q      <= out_row_d;
      out_col_q      <= out_col_d;
      out_rm18_q     <= out_rm18_d;
      out_rm10_q     <= out_rm10_d;
      pend_q         <= pend_d;
      min_q          <= min_d;
      max_q          <= max_d;
      out_vld_q      <= out_vld_d;
      emit_q         <= emit_d;
      gx_q           <= gx_d;
      gy_q           <= gy_d;
      rd_vld_q       <= rd_vld_d;
      rd_ctr_q       <= rd_ctr_d;
      div_go_q       <= div_go_d;
      sqrt_go_q      <= sqrt_go_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (vmem_we) vmem[in_rm18_q][in_col_q] <= v_pix;
    if (state_q == ST_GATHER) v_rd_q <= vmem[rd_row][rd_col];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem[swr_row_q][swr_col_q] <= vzero_q ? 8'h00 : div_res[7:0];
    if (state_q == ST_READS) s_rd_q <= smem[out_rm10_q][out_col_q];
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      swr_row_q <= in_rm10_q;
      swr_col_q <= in_col_q;
      vzero_q   <= (v_pix == 8'h00);
    end
    if (div_go_d) begin
      div_n_q <= div_n_d;
      div_d_q <= div_d_d;
    end
    if (sqrt_go_d) sqrt_x_q <= sqrt_x_d;

    if (state_q == ST_READS) begin
      sum_q <= '0;
      sq_q  <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + pgm_pkg::SUMW'(v_rd_q);
      sq_q  <= sq_q + pgm_pkg::SQW'(16'(v_rd_q) * 16'(v_rd_q));
    end
    if (rd_ctr_q) v_ctr_q <= v_rd_q;

    if (state_q == ST_PREP1) begin
      a289_q <= pgm_pkg::PRODW'(pgm_pkg::AREA) * pgm_pkg::PRODW'(sq_q);
      ss_q   <= pgm_pkg::PRODW'(sum_q) * pgm_pkg::PRODW'(sum_q);
      den_q  <= pgm_pkg::DENW'(sum_q) + pgm_pkg::DENW'(pgm_pkg::FLOOR_TERM);
    end
    if (state_q == ST_CDIV && dv_chain[pgm_pkg::DV_QW].vld) c_q <= div_res;
    if (state_q == ST_MUL1) m1_q <= 16'(v_ctr_q) * 16'(8'd255 - s_rd_q);
    if (state_q == ST_MUL2) m2_q <= 33'(m1_q) * 33'(17'h10000 - 17'(c_q));
    if (state_q == ST_PDIV && dv_chain[pgm_pkg::DV_QW].vld) p_q <= div_res;

    if (state_q == ST_EMIT && can_load) begin
      photometric_o    <= p_q;
      intensity_o      <= v_ctr_q;
      saturation_o     <= s_rd_q;
      local_contrast_o <= c_q;
      last_of_frame_o  <= last_nx;
      frame_min_o      <= last_nx ? min_nx : 16'h0000;
      frame_max_o      <= last_nx ? max_nx : 16'h0000;
    end
  end

  assign out_valid_o = out_vld_q;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

[bench/photometric_glare_map_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module photometric_glare_map_test;
  import pgm_pkg::*;

  localparam int MAXW      = 1024;
  localparam int LATENCY   = 500;       // settle time for one drained request
  localparam int HOLD_LEN  = 3000;      // long output hold-off
  localparam longint LIMIT = 6000000;

  localparam bit OP_PIXEL  = 1'b0;
  localparam bit OP_FLUSH  = 1'b1;
  localparam bit REG_WIDTH  = 1'b0;
  localparam bit REG_HEIGHT = 1'b1;

  typedef struct {
    bit       op;
    bit [7:0] b, g, r;
  } pixel_req_t;

  typedef struct {
    bit [15:0] photo;
    bit [7:0]  inten;
    bit [7:0]  sat;
    bit [15:0] contr;
    bit        last;
    bit [15:0] fmin;
    bit [15:0] fmax;
  } glare_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = 1'b0;
  logic [7:0]  blue_i = '0, green_i = '0, red_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] photometric_o, local_contrast_o, frame_min_o, frame_max_o;
  logic [7:0]  intensity_o, saturation_o;
  logic        last_of_frame_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  photometric_glare_map DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Glare predictor: own copy of the line stores, counters and frame extremes
  // ---------------------------------------------------------------------------
  bit [7:0]    value_rows [0:VROWS*MAXW-1];
  bit [7:0]    sat_rows   [0:SROWS*MAXW-1];
  int unsigned px_row, px_col, res_row, res_col, backlog;
  int unsigned low_mark, high_mark;
  int unsigned width_reg = 640, height_reg = 480;

  glare_t      glare_q[$];
  pixel_req_t  pixel_q[$];

  int unsigned errors, results_seen, frames_closed, items_queued;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return v < HALF + 1 ? HALF + 1 : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned mirror(int i, int unsigned n);
    if (i < 0) i = -i;
    if (i >= int'(n)) i = 2 * (int'(n) - 1) - i;
    if (i < 0) i = 0;
    return i;
  endfunction

  // round(65536*sqrt(d)/den), ties up, saturated: largest q with (2q-1)*den <= 2^17*sqrt(d)
  function automatic bit [15:0] contrast_of(bit [63:0] d, bit [63:0] den);
    bit [127:0] a, rhs;
    int unsigned lo, hi, mid;
    lo = 0;
    hi = 65535;
    rhs = {64'd0, d} << 34;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      a = (128'(2 * mid) - 1) * den;
      if (a * a <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic void restart_stream();
    px_row = 0; px_col = 0; res_row = 0; res_col = 0;
    backlog = 0;
    low_mark = 16'hFFFF;
    high_mark = 0;
  endfunction

  function automatic void produce_glare();
    int unsigned w, h, x, y, pv, v, s, c, p;
    bit [63:0] sum, sq, d, num;
    glare_t res;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    sum = 0;
    sq = 0;
    for (int dx = -HALF; dx <= HALF; dx++) begin
      x = mirror(int'(res_col) + dx, w);
      for (int dy = -HALF; dy <= HALF; dy++) begin
        y = mirror(int'(res_row) + dy, h);
        pv = value_rows[(y % VROWS) * MAXW + x];
        sum += pv;
        sq += pv * pv;
      end
    end
    d = (AREA * sq >= sum * sum) ? AREA * sq - sum * sum : 0;
    c = contrast_of(d, sum + FLOOR_TERM);
    v = value_rows[(res_row % VROWS) * MAXW + res_col];
    s = sat_rows[(res_row % SROWS) * MAXW + res_col];
    num = 64'(v) * (255 - s) * (65536 - c);
    p = (2 * num + P_ROUND) / P_DIVISOR;
    if (p > 65535) p = 65535;
    if (p < low_mark) low_mark = p;
    if (p > high_mark) high_mark = p;
    res.photo = p;
    res.inten = v;
    res.sat = s;
    res.contr = c;
    res.last = (res_row == h - 1 && res_col == w - 1);
    res.fmin = res.last ? low_mark[15:0] : 16'd0;
    res.fmax = res.last ? high_mark[15:0] : 16'd0;
    glare_q.push_back(res);
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
      if (res_row >= h) res_row = 0;
    end
    backlog--;
  endfunction

  function automatic void predict_request(pixel_req_t rq);
    int unsigned w, h, v, mn, s;
    bit at_start;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    at_start = (px_row == 0 && px_col == 0);
    if (rq.op == OP_FLUSH) begin
      if (at_start && backlog > 0) produce_glare();
      return;
    end
    v = rq.b; mn = rq.b;
    if (rq.g > v) v = rq.g;
    if (rq.r > v) v = rq.r;
    if (rq.g < mn) mn = rq.g;
    if (rq.r < mn) mn = rq.r;
    s = v ? (510 * (v - mn) + v) / (2 * v) : 0;
    if (at_start) restart_stream();
    value_rows[(px_row % VROWS) * MAXW + px_col] = v;
    sat_rows[(px_row % SROWS) * MAXW + px_col] = s;
    px_col++;
    if (px_col >= w) begin
      px_col = 0;
      px_row++;
      if (px_row >= h) px_row = 0;
    end
    backlog++;
    if (backlog > HALF * w + HALF) produce_glare();
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, fed from pixel_q
  // ---------------------------------------------------------------------------
  bit          req_taken;      // set on the rising edge that accepted a request
  bit          quiet;          // no idling in the closing part of the run
  int unsigned send_gap;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 9) - 1;
        in_valid_i <= 1'b0;
      end else begin
        pixel_req_t nx;
        nx = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= nx.op;
        blue_i <= nx.b;
        green_i <= nx.g;
        red_i <= nx.r;
      end
    end
  end

  // Result side stall: random bursts, plus one long hold-off on request
  bit          hold_req;
  int unsigned hold_cnt, stall_left;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_LEN) hold_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: prediction on accepted requests, checking on accepted results
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pixel_req_t rq;
        rq.op = opcode_i; rq.b = blue_i; rq.g = green_i; rq.r = red_i;
        predict_request(rq);
        req_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (glare_q.size() == 0) begin
          $error("result with nothing expected: photometric %0d", photometric_o);
          errors++;
        end else begin
          glare_t e;
          e = glare_q.pop_front();
          check_field("photometric", e.photo, photometric_o);
          check_field("intensity", e.inten, intensity_o);
          check_field("saturation", e.sat, saturation_o);
          check_field("local_contrast", e.contr, local_contrast_o);
          check_field("last_of_frame", e.last, last_of_frame_o);
          check_field("frame_min", e.fmin, frame_min_o);
          check_field("frame_max", e.fmax, frame_max_o);
          if (e.last) frames_closed++;
        end
      end
    end
  end

  longint cycles;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[photometric_glare_map] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(bit op, bit [7:0] b, bit [7:0] g, bit [7:0] r);
    pixel_req_t rq;
    rq.op = op; rq.b = b; rq.g = g; rq.r = r;
    pixel_q.push_back(rq);
    items_queued++;
  endtask

  // content style: 0 random, 1 flat colour, 2 dark noise, 3 bright with spikes
  task automatic push_pixel(int style, bit [7:0] base);
    case (style)
      1: begin
        push_req(OP_PIXEL, base, base ^ 8'h35, base >> 1);
      end
      2: begin
        push_req(OP_PIXEL, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      end
      3: begin
        if ($urandom_range(0, 7) == 0) push_req(OP_PIXEL, 0, 0, 0);
        else push_req(OP_PIXEL, $urandom_range(200, 255), $urandom_range(200, 255), 255);
      end
      default: begin
        push_req(OP_PIXEL, $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  // Whole frame, with an occasional stray flush mid-frame (yields nothing)
  task automatic push_frame(int unsigned n_px, int unsigned noise);
    int style;
    bit [7:0] base;
    style = $urandom_range(0, 3);
    base = $urandom;
    for (int i = 0; i < n_px; i++) begin
      if (i > 0 && $urandom_range(0, 99) < noise)
        push_req(OP_FLUSH, $urandom, $urandom, $urandom);
      push_pixel(style, base);
    end
  endtask

  task automatic push_flushes(int unsigned n);
    repeat (n) push_req(OP_FLUSH, $urandom, $urandom, $urandom);
  endtask

  // Wait until every request has gone in and every result has come out,
  // then give a pixel still in flight time to settle.
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid_i || glare_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(bit idx, bit [10:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
    restart_stream();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(bit [10:0] w, bit [10:0] h);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin
    int unsigned w, h, drain;
    restart_stream();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest frame, colour extremes, flush on an empty stream,
    // flush mid-frame and surplus flushes after the drain.
    set_size(11'd9, 11'd9);
    push_flushes(1);
    push_req(OP_PIXEL, 8'd0, 8'd0, 8'd0);
    push_req(OP_PIXEL, 8'd255, 8'd255, 8'd255);
    push_req(OP_PIXEL, 8'd255, 8'd0, 8'd0);
    push_req(OP_PIXEL, 8'd0, 8'd255, 8'd0);
    push_req(OP_PIXEL, 8'd0, 8'd0, 8'd255);
    push_flushes(1);
    push_req(OP_PIXEL, 8'd1, 8'd0, 8'd0);
    push_req(OP_PIXEL, 8'd1, 8'd1, 8'd1);
    push_req(OP_PIXEL, 8'd2, 8'd1, 8'd0);
    push_req(OP_PIXEL, 8'd128, 8'd127, 8'd255);
    push_req(OP_PIXEL, 8'd170, 8'd85, 8'd0);
    for (int i = 10; i < 81; i++) push_pixel(i % 4, 8'(i * 3));
    push_flushes(80 + 3);
    // second frame on the same size: extremes restart at its first pixel
    push_frame(81, 0);
    push_flushes(80);

    // Sizes below range clamp to HALF + 1; output held off for a long
    // stretch so the block backs up and stalls its input.
    set_size(11'd0, 11'd3);
    hold_cnt = 0;
    hold_req = 1'b1;
    push_frame(81, 5);
    push_flushes(80);

    // Largest and over-range sizes: a few pixels only, then aborted by the
    // next register write, which needs no result.
    set_size(11'd2047, 11'd2047);
    push_frame(40, 0);
    set_size(11'd1024, 11'd1024);
    push_frame(40, 0);
    set_size(11'd16, 11'd1023);
    push_frame(30, 0);

    // Random frames of small sizes; sometimes a frame is left half drained
    // and the next one drops its leftovers.
    while (items_queued < 1330) begin
      w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8) : $urandom_range(9, 16);
      h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 8) : $urandom_range(9, 12);
      if (items_queued > 1100) quiet = 1'b1;
      set_size(11'(w), 11'(h));
      w = clamp_dim(w, MAXW);
      h = clamp_dim(h, MAX_HEIGHT);
      drain = HALF * w + HALF;
      push_frame(w * h, 3);
      if ($urandom_range(0, 2) == 0) begin
        push_flushes($urandom_range(0, drain - 1));
        push_frame(w * h, 0);
      end
      push_flushes(drain + $urandom_range(0, 2));
    end

    settle();
    $display("Checked %0d glare results over %0d closed frames from %0d requests.",
             results_seen, frames_closed, items_queued);
    if (errors == 0) $display("[photometric_glare_map] OK");
    else $display("[photometric_glare_map] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
